// ===== rtl/adsr_pkg.sv =====
// adsr_pkg: shared widths, transaction kind codes, register indexes and phase codes
// for the adsr envelope generator; rate index helper for the step tables
// no dependencies
package adsr_pkg;

  localparam int STEP_W            = 27;
  localparam int LEVEL_W           = 10;
  localparam int KIND_W            = 3;
  localparam int IDX_W             = 6;
  localparam int CODE_W            = 4;
  localparam int PHASE_W           = 2;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 8;
  localparam int RATE_ENTRIES      = 64;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KEY_ON     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_KEY_OFF    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD_RISE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOAD_DECAY = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH     = 3'd6;

  localparam logic [PHASE_W-1:0] PH_ATTACK  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DECAY1  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DECAY2  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd3;

  localparam logic [CODE_W-1:0]  CODE_MAX  = 4'hf;
  localparam logic [IDX_W-1:0]   IDX_MAX   = 6'h3f;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = 10'h3ff;

  // table entry for a rate code and a signed key scale offset
  function automatic logic [IDX_W-1:0] rate_index(input logic [CODE_W-1:0] code,
                                                  input logic signed [6:0] scale);
    logic signed [7:0] sum;
    logic [IDX_W-1:0]  res;
    sum = $signed({2'b00, code, 2'b00}) + $signed({scale[6], scale});
    if (code == '0) begin
      res = '0;
    end else if (code == CODE_MAX) begin
      res = IDX_MAX;
    end else if (sum < 8'sd0) begin
      res = '0;
    end else if (sum > $signed({2'b00, IDX_MAX})) begin
      res = IDX_MAX;
    end else begin
      res = sum[IDX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/adsr_ifs.sv =====
// adsr channel interfaces: input transactions, result transactions, register writes
// each carries valid, ready and its payload; depends on adsr_pkg
interface adsr_in_if;
  logic                            valid;
  logic                            ready;
  logic [adsr_pkg::KIND_W-1:0]     kind;
  logic [adsr_pkg::IDX_W-1:0]      table_index;
  logic [adsr_pkg::STEP_W-1:0]     step_value;
  modport source(output valid, kind, table_index, step_value, input ready);
  modport sink(input valid, kind, table_index, step_value, output ready);
endinterface

interface adsr_out_if;
  logic                            valid;
  logic                            ready;
  logic [adsr_pkg::LEVEL_W-1:0]    level;
  logic [adsr_pkg::PHASE_W-1:0]    phase;
  logic                            active;
  modport source(output valid, level, phase, active, input ready);
  modport sink(input valid, level, phase, active, output ready);
endinterface

interface adsr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [adsr_pkg::CFG_IDX_W-1:0]  index;
  logic [adsr_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/adsr_envelope_generator.sv =====
// adsr_envelope_generator: one voice adsr envelope with key rate scaled step tables
// input transaction passes through the input register, then the result register
// throughput one transaction per cycle while the result channel is not stalled
// key on reads the step tables into the step registers at the update edge
// rst_n synchronous active low: clears cfg, valids, level, phase, play; tables not cleared
// depends on adsr_pkg and adsr_ifs
module adsr_envelope_generator #(
  parameter int FRACTION_BITS = adsr_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  adsr_in_if.sink     in_ch,
  adsr_out_if.source  out_ch,
  adsr_cfg_if.sink    cfg_ch
);

  localparam int WIDE_W = (FRACTION_BITS + adsr_pkg::LEVEL_W > adsr_pkg::STEP_W) ?
                          FRACTION_BITS + adsr_pkg::LEVEL_W : adsr_pkg::STEP_W;
  localparam int ACC_W  = WIDE_W + 1;
  localparam int INT_W  = ACC_W - FRACTION_BITS;
  localparam logic [ACC_W-1:0] TOP  =
    {{(ACC_W-adsr_pkg::LEVEL_W){1'b0}}, adsr_pkg::LEVEL_TOP} << FRACTION_BITS;
  localparam logic [ACC_W-1:0] HUGE = {{(ACC_W-1){1'b0}}, 1'b1} << (FRACTION_BITS + 10);

  logic [adsr_pkg::CODE_W-1:0] attack_code_r, decay1_code_r, decay2_code_r;
  logic [adsr_pkg::CODE_W-1:0] release_code_r, sustain_code_r, key_scale_r;
  logic [adsr_pkg::CFG_DATA_W-1:0] pitch_r;

  logic                          in_valid_r;
  logic [adsr_pkg::KIND_W-1:0]   in_kind_r;
  logic [adsr_pkg::IDX_W-1:0]    in_index_r;
  logic [adsr_pkg::STEP_W-1:0]   in_value_r;

  logic                          out_valid_r;
  logic [adsr_pkg::LEVEL_W-1:0]  out_level_r;
  logic [adsr_pkg::PHASE_W-1:0]  out_phase_r;
  logic                          out_active_r;

  logic [ACC_W-1:0]              acc_r, acc_nxt;
  logic [adsr_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic                          playing_r, playing_nxt;
  logic [adsr_pkg::STEP_W-1:0]   rise_step_r, fall1_step_r, fall2_step_r, end_step_r;

  logic [adsr_pkg::STEP_W-1:0] rise_mem   [adsr_pkg::RATE_ENTRIES];
  logic [adsr_pkg::STEP_W-1:0] decay_a_mem[adsr_pkg::RATE_ENTRIES];
  logic [adsr_pkg::STEP_W-1:0] decay_b_mem[adsr_pkg::RATE_ENTRIES];

  logic                          move;
  logic [3:0]                    octave;
  logic [5:0]                    oct_sum;
  logic signed [6:0]             scale;
  logic [adsr_pkg::IDX_W-1:0]    rise_idx, fall1_idx, fall2_idx, end_idx;
  logic [ACC_W-1:0]              rise_sum;
  logic [INT_W-1:0]              sustain_thr;

  function automatic logic [ACC_W-1:0] fall(input logic [ACC_W-1:0] v,
                                            input logic [adsr_pkg::STEP_W-1:0] step);
    logic [ACC_W-1:0] s;
    s = {{(ACC_W-adsr_pkg::STEP_W){1'b0}}, step};
    return (s >= v) ? '0 : v - s;
  endfunction

  assign move         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || move;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.level  = out_level_r;
  assign out_ch.phase  = out_phase_r;
  assign out_ch.active = out_active_r;

  // key rate scale: (octave + key_scale) * 2 + half step bit; zero when key_scale is CODE_MAX
  assign octave  = pitch_r[7:4] - 4'd1;
  assign oct_sum = {{2{octave[3]}}, octave} + {2'b00, key_scale_r};
  assign scale   = (key_scale_r == adsr_pkg::CODE_MAX) ? 7'sd0 : $signed({oct_sum, pitch_r[3]});

  assign rise_idx  = adsr_pkg::rate_index(attack_code_r, scale);
  assign fall1_idx = adsr_pkg::rate_index(decay1_code_r, scale);
  assign fall2_idx = adsr_pkg::rate_index(decay2_code_r, scale);
  assign end_idx   = adsr_pkg::rate_index(release_code_r, scale);

  assign rise_sum    = acc_r + {{(ACC_W-adsr_pkg::STEP_W){1'b0}}, rise_step_r};
  assign sustain_thr = {{(INT_W-adsr_pkg::LEVEL_W){1'b0}},
                        adsr_pkg::CODE_MAX - sustain_code_r, 6'b000000};

  always_comb begin
    acc_nxt     = acc_r;
    phase_nxt   = phase_r;
    playing_nxt = playing_r;
    case (in_kind_r)
      adsr_pkg::KIND_TICK: begin
        if (playing_r) begin
          case (phase_r)
            adsr_pkg::PH_ATTACK: begin
              if (rise_sum >= TOP) begin
                acc_nxt   = TOP;
                phase_nxt = ({{(ACC_W-adsr_pkg::STEP_W){1'b0}}, fall1_step_r} >= HUGE) ?
                            adsr_pkg::PH_DECAY2 : adsr_pkg::PH_DECAY1;
              end else begin
                acc_nxt = rise_sum;
              end
            end
            adsr_pkg::PH_DECAY1: begin
              acc_nxt = fall(acc_r, fall1_step_r);
              if (acc_nxt[ACC_W-1:FRACTION_BITS] <= sustain_thr) begin
                phase_nxt = adsr_pkg::PH_DECAY2;
              end
            end
            adsr_pkg::PH_DECAY2: begin
              acc_nxt = fall(acc_r, fall2_step_r);
            end
            default: begin
              acc_nxt = fall(acc_r, end_step_r);
              if (acc_nxt == '0) begin
                playing_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      adsr_pkg::KIND_KEY_ON: begin
        acc_nxt     = '0;
        phase_nxt   = adsr_pkg::PH_ATTACK;
        playing_nxt = 1'b1;
      end
      adsr_pkg::KIND_KEY_OFF: begin
        if (playing_r) begin
          if (release_code_r != adsr_pkg::CODE_MAX) begin
            phase_nxt = adsr_pkg::PH_RELEASE;
          end else begin
            playing_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_code_r  <= '0;
      decay1_code_r  <= '0;
      decay2_code_r  <= '0;
      release_code_r <= '0;
      sustain_code_r <= '0;
      key_scale_r    <= '0;
      pitch_r        <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        adsr_pkg::CFG_ATTACK:    attack_code_r  <= cfg_ch.data[adsr_pkg::CODE_W-1:0];
        adsr_pkg::CFG_DECAY1:    decay1_code_r  <= cfg_ch.data[adsr_pkg::CODE_W-1:0];
        adsr_pkg::CFG_DECAY2:    decay2_code_r  <= cfg_ch.data[adsr_pkg::CODE_W-1:0];
        adsr_pkg::CFG_RELEASE:   release_code_r <= cfg_ch.data[adsr_pkg::CODE_W-1:0];
        adsr_pkg::CFG_SUSTAIN:   sustain_code_r <= cfg_ch.data[adsr_pkg::CODE_W-1:0];
        adsr_pkg::CFG_KEY_SCALE: key_scale_r    <= cfg_ch.data[adsr_pkg::CODE_W-1:0];
        adsr_pkg::CFG_PITCH:     pitch_r        <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      acc_r        <= '0;
      phase_r      <= adsr_pkg::PH_ATTACK;
      playing_r    <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (move) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        phase_r     <= phase_nxt;
        playing_r   <= playing_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_kind_r  <= in_ch.kind;
      in_index_r <= in_ch.table_index;
      in_value_r <= in_ch.step_value;
    end
    if (move) begin
      out_level_r  <= acc_nxt[FRACTION_BITS+adsr_pkg::LEVEL_W-1:FRACTION_BITS];
      out_phase_r  <= phase_nxt;
      out_active_r <= playing_nxt;
    end
  end

  // step tables; the decay table is kept twice for its three key on reads
  always_ff @(posedge clk) begin
    if (move) begin
      case (in_kind_r)
        adsr_pkg::KIND_LOAD_RISE: begin
          rise_mem[in_index_r] <= in_value_r;
        end
        adsr_pkg::KIND_LOAD_DECAY: begin
          decay_a_mem[in_index_r] <= in_value_r;
          decay_b_mem[in_index_r] <= in_value_r;
        end
        adsr_pkg::KIND_KEY_ON: begin
          rise_step_r  <= rise_mem[rise_idx];
          fall1_step_r <= decay_a_mem[fall1_idx];
          fall2_step_r <= decay_a_mem[fall2_idx];
          end_step_r   <= decay_b_mem[end_idx];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
